// ===== hw/rtl/gb3_pkg.sv =====
// gb3_pkg: shared types and constants of the 3x3 Gaussian blur block.
// Used by gb3_linebuf, gb3_cell, gb3_filter and gaussian_blur_3x3_rgb; depends on nothing.

package gb3_pkg;

  localparam int unsigned WIN = 3;
  localparam int unsigned CFG_W = 11;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_t;

  typedef struct packed {
    pix_t top;
    pix_t mid;
    pix_t bot;
  } col_t;

  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_DRAIN = 1'b1;

  localparam logic [1:0] REG_LINE_WIDTH   = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;

  localparam logic [CFG_W-1:0] LINE_WIDTH_RST   = 11'd640;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 11'd480;
  localparam logic [CFG_W-1:0] LINE_MIN         = 11'd3;
  localparam logic [CFG_W-1:0] HEIGHT_MIN       = 11'd3;
  localparam logic [CFG_W-1:0] HEIGHT_MAX       = 11'd1024;

endpackage

// ===== hw/rtl/gb3_linebuf.sv =====
// gb3_linebuf: one line of pixels, one read and one write port, registered read.
// Depends on gb3_pkg for the pixel type.

module gb3_linebuf #(
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic            clk_i,
  input  logic            re_i,
  input  logic [AW-1:0]   raddr_i,
  output gb3_pkg::pix_t   rdata_o,
  input  logic            we_i,
  input  logic [AW-1:0]   waddr_i,
  input  gb3_pkg::pix_t   wdata_i
);

  gb3_pkg::pix_t mem_q [DEPTH];
  gb3_pkg::pix_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/gb3_cell.sv =====
// gb3_cell: one column of the 3x3 window; takes the column of its right neighbor.
// Depends on gb3_pkg for the column type.

module gb3_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  gb3_pkg::col_t col_i,
  output gb3_pkg::col_t col_o
);

  gb3_pkg::col_t col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else if (en_i) begin
      col_q <= col_i;
    end
  end

  assign col_o = col_q;

endmodule

// ===== hw/rtl/gb3_filter.sv =====
// gb3_filter: 1-2-1 / 2-4-2 / 1-2-1 weighted sum over the window, divide by 16.
// Border pixels take the window center. Depends on gb3_pkg.

module gb3_filter (
  input  gb3_pkg::col_t win_i [gb3_pkg::WIN],
  input  logic          border_i,
  output gb3_pkg::pix_t pix_o
);

  function automatic logic [7:0] blur_ch(
    input logic [7:0] a, input logic [7:0] b, input logic [7:0] c,
    input logic [7:0] d, input logic [7:0] e, input logic [7:0] f,
    input logic [7:0] g, input logic [7:0] h, input logic [7:0] k
  );
    logic [11:0] sum;
    sum = 12'(a) + 12'(c) + 12'(g) + 12'(k)
        + ((12'(b) + 12'(d) + 12'(f) + 12'(h)) << 1)
        + (12'(e) << 2);
    return sum[11:4];
  endfunction

  gb3_pkg::pix_t smooth;

  always_comb begin
    smooth.red = blur_ch(
      win_i[0].top.red, win_i[1].top.red, win_i[2].top.red,
      win_i[0].mid.red, win_i[1].mid.red, win_i[2].mid.red,
      win_i[0].bot.red, win_i[1].bot.red, win_i[2].bot.red);
    smooth.green = blur_ch(
      win_i[0].top.green, win_i[1].top.green, win_i[2].top.green,
      win_i[0].mid.green, win_i[1].mid.green, win_i[2].mid.green,
      win_i[0].bot.green, win_i[1].bot.green, win_i[2].bot.green);
    smooth.blue = blur_ch(
      win_i[0].top.blue, win_i[1].top.blue, win_i[2].top.blue,
      win_i[0].mid.blue, win_i[1].mid.blue, win_i[2].mid.blue,
      win_i[0].bot.blue, win_i[1].bot.blue, win_i[2].bot.blue);
  end

  assign pix_o = border_i ? win_i[1].mid : smooth;

endmodule

// ===== hw/rtl/gaussian_blur_3x3_rgb.sv =====
// gaussian_blur_3x3_rgb: streaming 3x3 Gaussian smoothing of RGB raster frames.
// Depends on gb3_pkg, gb3_linebuf, gb3_cell and gb3_filter.
//
// Input channel: in_valid_i / in_ready_o with action_i and one RGB pixel per
// beat. A drain beat inside the frame is taken and dropped; after the last
// pixel of a frame, line_width + 1 drain beats flush the tail. Output channel:
// out_valid_o / out_ready_i handshake, carrying the
// smoothed pixel and frame_end_o on the last pixel of the frame. Results run
// one line and one pixel behind the input in raster order; border rows and
// columns pass through unchanged.
// Throughput: one beat per cycle while the receiver takes results. The result a
// beat completes is formed by the line buffer read at its accepting edge, the
// window shift through the chain of three column cells and the output register.
// When the receiver stalls, the output register holds and in_ready_o drops in
// the same cycle; the whole chain holds with it. Reset clears the counters,
// the window and the output valid and frame-end flags and loads 640 x 480; the
// line buffers need no clearing. A configuration write restarts the frame.

module gaussian_blur_3x3_rgb #(
  parameter int unsigned MAX_LINE = 1024
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [1:0]               cfg_idx_i,
  input  logic [gb3_pkg::CFG_W-1:0] cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     action_i,
  input  logic [7:0]               red_in_i,
  input  logic [7:0]               green_in_i,
  input  logic [7:0]               blue_in_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [7:0]               red_out_o,
  output logic [7:0]               green_out_o,
  output logic [7:0]               blue_out_o,
  output logic                     frame_end_o
);

  localparam int unsigned AW = (MAX_LINE > 1) ? $clog2(MAX_LINE) : 1;
  localparam int unsigned WB = $clog2(MAX_LINE + 1);
  localparam int unsigned WW = (WB > gb3_pkg::CFG_W) ? WB : gb3_pkg::CFG_W;
  localparam int unsigned RW = gb3_pkg::CFG_W;

  logic [gb3_pkg::CFG_W-1:0] line_width_q, frame_height_q;
  logic [AW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;

  logic [WW-1:0] lw_ext, w_val;
  logic [RW-1:0] h_val;
  logic cfg_hit;
  logic in_frame, proc, accept, acc_proc, en;
  logic c_is0, c_is1, col_last, emit, border, last;
  gb3_pkg::pix_t px;

  logic s1_valid_q, s1_emit_q, s1_border_q, s1_last_q, s1_fwd_q;
  logic [AW-1:0] s1_ci_q;
  gb3_pkg::pix_t s1_px_q;
  gb3_pkg::pix_t last_mid_q;
  logic s2_valid_q, s2_border_q, s2_last_q;

  gb3_pkg::pix_t up_rdata, mid_rdata, top_px, filt, out_pix_q;
  logic out_valid_q, out_last_q;
  gb3_pkg::col_t new_col;
  gb3_pkg::col_t win [gb3_pkg::WIN];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q   <= gb3_pkg::LINE_WIDTH_RST;
      frame_height_q <= gb3_pkg::FRAME_HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        gb3_pkg::REG_LINE_WIDTH:   line_width_q   <= cfg_data_i;
        gb3_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_hit = cfg_we_i && ((cfg_idx_i == gb3_pkg::REG_LINE_WIDTH) ||
                                (cfg_idx_i == gb3_pkg::REG_FRAME_HEIGHT));

  always_comb begin
    lw_ext = WW'(line_width_q);
    if (lw_ext < WW'(gb3_pkg::LINE_MIN)) begin
      w_val = WW'(gb3_pkg::LINE_MIN);
    end else if (lw_ext > WW'(MAX_LINE)) begin
      w_val = WW'(MAX_LINE);
    end else begin
      w_val = lw_ext;
    end
    if (frame_height_q < gb3_pkg::HEIGHT_MIN) begin
      h_val = gb3_pkg::HEIGHT_MIN;
    end else if (frame_height_q > gb3_pkg::HEIGHT_MAX) begin
      h_val = gb3_pkg::HEIGHT_MAX;
    end else begin
      h_val = frame_height_q;
    end
  end

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;
  assign accept     = in_valid_i && in_ready_o;
  assign in_frame   = row_q < h_val;
  assign proc       = !(in_frame && (action_i == gb3_pkg::ACT_DRAIN));
  assign acc_proc   = accept && proc;

  always_comb begin
    if (in_frame) begin
      px.red   = red_in_i;
      px.green = green_in_i;
      px.blue  = blue_in_i;
    end else begin
      px = '0;
    end
  end

  assign c_is0    = col_q == '0;
  assign c_is1    = col_q == AW'(1);
  assign col_last = (WW'(col_q) + WW'(1)) >= w_val;
  assign emit     = (row_q >= RW'(2)) || ((row_q == RW'(1)) && !c_is0);
  assign border   = c_is0 || c_is1 || (row_q == RW'(1)) || (row_q == h_val);
  assign last     = c_is0 && (row_q == h_val + RW'(1));

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (last) begin
      col_d = '0;
      row_d = '0;
    end else if (col_last) begin
      col_d = '0;
      row_d = row_q + RW'(1);
    end else begin
      col_d = col_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cfg_hit) begin
      col_q <= '0;
      row_q <= '0;
    end else if (acc_proc) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  gb3_linebuf #(.DEPTH(MAX_LINE)) u_mid_buf (
    .clk_i   (clk_i),
    .re_i    (acc_proc),
    .raddr_i (col_q),
    .rdata_o (mid_rdata),
    .we_i    (acc_proc),
    .waddr_i (col_q),
    .wdata_i (px)
  );

  gb3_linebuf #(.DEPTH(MAX_LINE)) u_up_buf (
    .clk_i   (clk_i),
    .re_i    (acc_proc),
    .raddr_i (col_q),
    .rdata_o (up_rdata),
    .we_i    (en && s1_valid_q),
    .waddr_i (s1_ci_q),
    .wdata_i (mid_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s1_emit_q   <= 1'b0;
      s1_border_q <= 1'b0;
      s1_last_q   <= 1'b0;
      s1_fwd_q    <= 1'b0;
      s2_valid_q  <= 1'b0;
      s2_border_q <= 1'b0;
      s2_last_q   <= 1'b0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
    end else if (en) begin
      s1_valid_q  <= acc_proc;
      s1_emit_q   <= emit;
      s1_border_q <= border;
      s1_last_q   <= last;
      s1_fwd_q    <= s1_valid_q && (s1_ci_q == col_q);
      s2_valid_q  <= s1_valid_q && s1_emit_q;
      s2_border_q <= s1_border_q;
      s2_last_q   <= s1_last_q;
      out_valid_q <= s2_valid_q;
      if (s2_valid_q) begin
        out_last_q <= s2_last_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_proc) begin
      s1_ci_q <= col_q;
      s1_px_q <= px;
    end
    if (en && s1_valid_q) begin
      last_mid_q <= mid_rdata;
    end
    if (en && s2_valid_q) begin
      out_pix_q <= filt;
    end
  end

  assign top_px      = s1_fwd_q ? last_mid_q : up_rdata;
  assign new_col.top = top_px;
  assign new_col.mid = mid_rdata;
  assign new_col.bot = s1_px_q;

  for (genvar j = 0; j < gb3_pkg::WIN; j++) begin : g_cell
    if (j == gb3_pkg::WIN - 1) begin : g_head
      gb3_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .en_i   (en && s1_valid_q),
        .col_i  (new_col),
        .col_o  (win[j])
      );
    end else begin : g_body
      gb3_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .en_i   (en && s1_valid_q),
        .col_i  (win[j+1]),
        .col_o  (win[j])
      );
    end
  end

  gb3_filter u_filter (
    .win_i    (win),
    .border_i (s2_border_q),
    .pix_o    (filt)
  );

  assign out_valid_o = out_valid_q;
  assign red_out_o   = out_pix_q.red;
  assign green_out_o = out_pix_q.green;
  assign blue_out_o  = out_pix_q.blue;
  assign frame_end_o = out_last_q;

endmodule

// ===== hw/rtl/gb3_checker.sv =====
// gb3_checker: port-level assertions on gaussian_blur_3x3_rgb, bound to it below.
// Depends only on the handshake and result ports of the top level.

module gb3_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] red_out_o,
  input logic [7:0] green_out_o,
  input logic [7:0] blue_out_o,
  input logic       frame_end_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(red_out_o)
      && $stable(green_out_o) && $stable(blue_out_o) && $stable(frame_end_o))
    else $error("output beat changed while stalled");

  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input blocked without an output stall");

  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o || out_ready_i |-> in_ready_o)
    else $error("input blocked while output register frees");

endmodule

bind gaussian_blur_3x3_rgb gb3_checker u_checker (.*);

// ===== verif/gaussian_blur_3x3_rgb_tb.sv =====
// gaussian_blur_3x3_rgb_tb: self-checking bench for the streaming 3x3 RGB blur.
// A short directed run with pinned results is followed by random frames checked
// against an in-bench line-buffer predictor. Depends on gb3_pkg and the RTL.

module gaussian_blur_3x3_rgb_tb;

  localparam int unsigned LINE_MAX_PX   = 1024;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned END_CYCLES    = 20;
  localparam int unsigned RAND_BEATS    = 700;
  localparam int unsigned MAX_REPORTS   = 10;
  localparam int unsigned TAP_WT [9]    = '{1, 2, 1, 2, 4, 2, 1, 2, 1};

  typedef struct packed {
    gb3_pkg::pix_t px;
    logic          frame_end;
  } blur_res_t;

  typedef enum logic [1:0] {PIN_PREDICT, PIN_NONE, PIN_RESULT} pin_e;
  typedef enum logic {ROW_BEAT, ROW_REG} row_e;

  typedef struct packed {
    row_e                      kind;
    logic [1:0]                idx;
    logic [gb3_pkg::CFG_W-1:0] val;
    logic                      act;
    gb3_pkg::pix_t             px;
    pin_e                      pin;
    blur_res_t                 res;
  } stim_row_t;

  localparam gb3_pkg::pix_t RED_FULL   = 24'hFF0000;
  localparam gb3_pkg::pix_t RED_BLUE80 = 24'hFF0080;
  localparam gb3_pkg::pix_t RED_BLUE20 = 24'hFF0020;
  localparam gb3_pkg::pix_t CYAN_FULL  = 24'h00FFFF;

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      cfg_we_i;
  logic [1:0]                cfg_idx_i;
  logic [gb3_pkg::CFG_W-1:0] cfg_data_i;
  logic                      in_valid_i;
  logic                      in_ready_o;
  logic                      action_i;
  logic [7:0]                red_in_i;
  logic [7:0]                green_in_i;
  logic [7:0]                blue_in_i;
  logic                      out_valid_o;
  logic                      out_ready_i;
  logic [7:0]                red_out_o;
  logic [7:0]                green_out_o;
  logic [7:0]                blue_out_o;
  logic                      frame_end_o;

  pin_e      pin_kind;
  blur_res_t pin_res;

  gb3_pkg::pix_t             older_line [LINE_MAX_PX];
  gb3_pkg::pix_t             newer_line [LINE_MAX_PX];
  gb3_pkg::pix_t             tap_win [9];
  int unsigned               at_row;
  int unsigned               at_col;
  logic [gb3_pkg::CFG_W-1:0] width_reg;
  logic [gb3_pkg::CFG_W-1:0] height_reg;

  blur_res_t   smoothed_q [$];
  int unsigned err_cnt   = 0;
  int unsigned fed_beats = 0;
  int unsigned gap_pct   = 0;
  int unsigned stall_pct = 0;
  bit          hold_off  = 1'b0;

  gaussian_blur_3x3_rgb #(
    .MAX_LINE(LINE_MAX_PX)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .action_i   (action_i),
    .red_in_i   (red_in_i),
    .green_in_i (green_in_i),
    .blue_in_i  (blue_in_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .red_out_o  (red_out_o),
    .green_out_o(green_out_o),
    .blue_out_o (blue_out_o),
    .frame_end_o(frame_end_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned clamp_dim(input logic [gb3_pkg::CFG_W-1:0] v,
                                            input int unsigned lo, input int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void blur_set_reg(input logic [1:0] idx,
                                       input logic [gb3_pkg::CFG_W-1:0] val);
    if (idx == gb3_pkg::REG_LINE_WIDTH) width_reg = val;
    else if (idx == gb3_pkg::REG_FRAME_HEIGHT) height_reg = val;
    else return;
    at_row = 0;
    at_col = 0;
  endfunction

  function automatic bit blur_advance(input logic act, input gb3_pkg::pix_t px_in,
                                      output blur_res_t res);
    int unsigned   w, h, r, c, orow, ocol, sr, sg, sb;
    gb3_pkg::pix_t px, top, mid;
    bit            border;
    w = clamp_dim(width_reg, gb3_pkg::LINE_MIN, LINE_MAX_PX);
    h = clamp_dim(height_reg, gb3_pkg::HEIGHT_MIN, gb3_pkg::HEIGHT_MAX);
    r = at_row;
    c = at_col;
    res = '0;
    if (r < h && act == gb3_pkg::ACT_DRAIN) return 1'b0;
    px = (r < h) ? px_in : '0;
    top = older_line[c];
    mid = newer_line[c];
    older_line[c] = mid;
    newer_line[c] = px;
    for (int k = 0; k < 3; k++) begin
      tap_win[3*k]   = tap_win[3*k+1];
      tap_win[3*k+1] = tap_win[3*k+2];
    end
    tap_win[2] = top;
    tap_win[5] = mid;
    tap_win[8] = px;
    if (c + 1 >= w) begin
      at_col = 0;
      at_row = r + 1;
    end else begin
      at_col = c + 1;
    end
    if (r < 2 && !(r == 1 && c >= 1)) return 1'b0;
    if (c >= 1) begin
      orow = r - 1;
      ocol = c - 1;
    end else begin
      orow = r - 2;
      ocol = w - 1;
    end
    border = orow == 0 || orow == h - 1 || ocol == 0 || ocol == w - 1;
    res.frame_end = orow == h - 1 && ocol == w - 1;
    if (res.frame_end) begin
      at_row = 0;
      at_col = 0;
    end
    sr = 0;
    sg = 0;
    sb = 0;
    for (int k = 0; k < 9; k++) begin
      sr += TAP_WT[k] * tap_win[k].red;
      sg += TAP_WT[k] * tap_win[k].green;
      sb += TAP_WT[k] * tap_win[k].blue;
    end
    if (border) begin
      res.px = tap_win[4];
    end else begin
      res.px.red   = 8'(sr / 16);
      res.px.green = 8'(sg / 16);
      res.px.blue  = 8'(sb / 16);
    end
    return 1'b1;
  endfunction

  task automatic log_miss(input string why, input blur_res_t want, input blur_res_t got);
    err_cnt++;
    if (err_cnt <= MAX_REPORTS)
      $display("%0t %s: exp r=%h g=%h b=%h end=%b  got r=%h g=%h b=%h end=%b", $realtime,
               why, want.px.red, want.px.green, want.px.blue, want.frame_end,
               got.px.red, got.px.green, got.px.blue, got.frame_end);
  endtask

  always @(posedge clk_i) begin
    blur_res_t want, got;
    bit        made;
    if (!rst_ni) begin
      width_reg  = gb3_pkg::LINE_WIDTH_RST;
      height_reg = gb3_pkg::FRAME_HEIGHT_RST;
      at_row = 0;
      at_col = 0;
      foreach (tap_win[i]) tap_win[i] = '0;
      foreach (older_line[i]) begin
        older_line[i] = '0;
        newer_line[i] = '0;
      end
    end else begin
      if (cfg_we_i) blur_set_reg(cfg_idx_i, cfg_data_i);
      if (in_valid_i && in_ready_o) begin
        made = blur_advance(action_i, {red_in_i, green_in_i, blue_in_i}, want);
        case (pin_kind)
          PIN_PREDICT: if (made) smoothed_q = {smoothed_q, want};
          PIN_RESULT:  smoothed_q = {smoothed_q, pin_res};
          default: ;
        endcase
      end
      if (out_valid_o && out_ready_i) begin
        got.px = {red_out_o, green_out_o, blue_out_o};
        got.frame_end = frame_end_o;
        if (smoothed_q.size() == 0) begin
          log_miss("unexpected beat", '0, got);
        end else begin
          want = smoothed_q.pop_front();
          if (got.px.red !== want.px.red || got.px.green !== want.px.green ||
              got.px.blue !== want.px.blue || got.frame_end !== want.frame_end)
            log_miss("mismatch", want, got);
        end
      end
    end
  end

  initial begin
    int unsigned hold;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off || $urandom_range(0, 99) >= stall_pct) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b0;
        hold = $urandom_range(1, 5);
        repeat (hold - 1) @(posedge clk_i);
      end
    end
  end

  function automatic gb3_pkg::pix_t rand_pix();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return {8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255))};
    endcase
  endfunction

  function automatic stim_row_t beat_row(input logic act, input gb3_pkg::pix_t px,
                                         input pin_e pin, input gb3_pkg::pix_t res_px,
                                         input logic fe);
    stim_row_t row;
    row = '0;
    row.kind = ROW_BEAT;
    row.act = act;
    row.px = px;
    row.pin = pin;
    row.res = {res_px, fe};
    return row;
  endfunction

  function automatic stim_row_t reg_row(input logic [1:0] idx,
                                        input logic [gb3_pkg::CFG_W-1:0] val);
    stim_row_t row;
    row = '0;
    row.kind = ROW_REG;
    row.idx = idx;
    row.val = val;
    row.pin = PIN_PREDICT;
    return row;
  endfunction

  task automatic send_beat(input logic act, input gb3_pkg::pix_t px, input pin_e pin,
                           input blur_res_t res);
    int unsigned gap;
    if ($urandom_range(0, 99) < gap_pct) begin
      gap = $urandom_range(1, 5);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    red_in_i   <= px.red;
    green_in_i <= px.green;
    blue_in_i  <= px.blue;
    pin_kind   <= pin;
    pin_res    <= res;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [gb3_pkg::CFG_W-1:0] val);
    in_valid_i <= 1'b0;
    while (smoothed_q.size() != 0) @(posedge clk_i);
    hold_off = 1'b1;
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    hold_off = 1'b0;
  endtask

  task automatic blur_frame(input logic [gb3_pkg::CFG_W-1:0] w_reg,
                            input logic [gb3_pkg::CFG_W-1:0] h_reg,
                            input bit reprog, input bit rough, output bit clean);
    int unsigned w, h, n_pix, n_tail;
    bit          partial;
    w = clamp_dim(w_reg, gb3_pkg::LINE_MIN, LINE_MAX_PX);
    h = clamp_dim(h_reg, gb3_pkg::HEIGHT_MIN, gb3_pkg::HEIGHT_MAX);
    if (reprog) begin
      write_reg(gb3_pkg::REG_LINE_WIDTH, w_reg);
      write_reg(gb3_pkg::REG_FRAME_HEIGHT, h_reg);
    end
    partial = rough && $urandom_range(0, 7) == 0;
    n_pix = partial ? $urandom_range(1, w * h - 1) : w * h;
    n_tail = w + 1;
    if (rough && $urandom_range(0, 7) == 0) n_tail = $urandom_range(0, w + 4);
    for (int i = 0; i < n_pix; i++) begin
      if ($urandom_range(0, 15) == 0)
        send_beat(gb3_pkg::ACT_DRAIN, rand_pix(), PIN_PREDICT, '0);
      send_beat(gb3_pkg::ACT_PIXEL, rand_pix(), PIN_PREDICT, '0);
      fed_beats++;
    end
    if (!partial) begin
      for (int i = 0; i < n_tail; i++) begin
        send_beat($urandom_range(0, 3) == 0 ? gb3_pkg::ACT_PIXEL : gb3_pkg::ACT_DRAIN,
                  rand_pix(), PIN_PREDICT, '0);
        fed_beats++;
      end
    end
    clean = !partial && n_tail == w + 1;
  endtask

  task automatic pick_idling();
    case ($urandom_range(0, 2))
      0:       gap_pct = 0;
      1:       gap_pct = 10;
      default: gap_pct = 35;
    endcase
    case ($urandom_range(0, 2))
      0:       stall_pct = 0;
      1:       stall_pct = 10;
      default: stall_pct = 35;
    endcase
  endtask

  initial begin
    stim_row_t                 dir_q [$];
    bit                        clean;
    bit                        reprog;
    logic [gb3_pkg::CFG_W-1:0] w_reg, h_reg;
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= gb3_pkg::REG_LINE_WIDTH;
    cfg_data_i  <= '0;
    in_valid_i  <= 1'b0;
    action_i    <= gb3_pkg::ACT_PIXEL;
    red_in_i    <= '0;
    green_in_i  <= '0;
    blue_in_i   <= '0;
    pin_kind    <= PIN_PREDICT;
    pin_res     <= '0;

    // 640 x 480 after reset: nothing comes out yet
    dir_q = {dir_q, beat_row(gb3_pkg::ACT_PIXEL, 24'h123456, PIN_NONE, '0, 1'b0)};
    dir_q = {dir_q, beat_row(gb3_pkg::ACT_PIXEL, 24'h000000, PIN_NONE, '0, 1'b0)};
    dir_q = {dir_q, beat_row(gb3_pkg::ACT_DRAIN, 24'hFFFFFF, PIN_NONE, '0, 1'b0)};
    // out-of-range writes saturate to 3 x 3 and restart the frame
    dir_q = {dir_q, reg_row(gb3_pkg::REG_LINE_WIDTH, 11'd2)};
    dir_q = {dir_q, reg_row(gb3_pkg::REG_FRAME_HEIGHT, 11'd0)};
    dir_q = {dir_q, beat_row(gb3_pkg::ACT_PIXEL, RED_FULL, PIN_NONE, '0, 1'b0)};
    dir_q = {dir_q, beat_row(gb3_pkg::ACT_PIXEL, RED_FULL, PIN_NONE, '0, 1'b0)};
    dir_q = {dir_q, beat_row(gb3_pkg::ACT_DRAIN, CYAN_FULL, PIN_NONE, '0, 1'b0)};
    dir_q = {dir_q, beat_row(gb3_pkg::ACT_PIXEL, RED_FULL, PIN_NONE, '0, 1'b0)};
    dir_q = {dir_q, beat_row(gb3_pkg::ACT_PIXEL, RED_FULL, PIN_NONE, '0, 1'b0)};
    dir_q = {dir_q, beat_row(gb3_pkg::ACT_PIXEL, RED_BLUE80, PIN_RESULT, RED_FULL, 1'b0)};
    dir_q = {dir_q, beat_row(gb3_pkg::ACT_PIXEL, RED_FULL, PIN_RESULT, RED_FULL, 1'b0)};
    dir_q = {dir_q, beat_row(gb3_pkg::ACT_PIXEL, RED_FULL, PIN_RESULT, RED_FULL, 1'b0)};
    dir_q = {dir_q, beat_row(gb3_pkg::ACT_PIXEL, RED_FULL, PIN_RESULT, RED_FULL, 1'b0)};
    dir_q = {dir_q, beat_row(gb3_pkg::ACT_PIXEL, RED_FULL, PIN_RESULT, RED_BLUE20, 1'b0)};
    // tail: a pixel here is dropped like a drain beat
    dir_q = {dir_q, beat_row(gb3_pkg::ACT_DRAIN, 24'h000000, PIN_RESULT, RED_FULL, 1'b0)};
    dir_q = {dir_q, beat_row(gb3_pkg::ACT_PIXEL, CYAN_FULL, PIN_RESULT, RED_FULL, 1'b0)};
    dir_q = {dir_q, beat_row(gb3_pkg::ACT_DRAIN, 24'h000000, PIN_RESULT, RED_FULL, 1'b0)};
    dir_q = {dir_q, beat_row(gb3_pkg::ACT_DRAIN, 24'h000000, PIN_RESULT, RED_FULL, 1'b1)};
    dir_q = {dir_q, beat_row(gb3_pkg::ACT_DRAIN, CYAN_FULL, PIN_NONE, '0, 1'b0)};

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    gap_pct   = 20;
    stall_pct = 20;
    foreach (dir_q[i]) begin
      if (dir_q[i].kind == ROW_REG) write_reg(dir_q[i].idx, dir_q[i].val);
      else send_beat(dir_q[i].act, dir_q[i].px, dir_q[i].pin, dir_q[i].res);
    end

    clean = 1'b0;
    w_reg = 11'd3;
    h_reg = 11'd3;
    while (fed_beats < RAND_BEATS) begin
      reprog = !clean || $urandom_range(0, 3) != 0;
      if (reprog) begin
        w_reg = $urandom_range(0, 7) == 0 ? 11'($urandom_range(0, 2)) :
                                            11'($urandom_range(3, 12));
        h_reg = $urandom_range(0, 7) == 0 ? 11'($urandom_range(0, 2)) :
                                            11'($urandom_range(3, 8));
      end
      pick_idling();
      blur_frame(w_reg, h_reg, reprog, 1'b1, clean);
    end

    gap_pct   = 0;
    stall_pct = 0;
    blur_frame(11'($urandom_range(3, 12)), 11'($urandom_range(3, 8)), 1'b1, 1'b0, clean);
    blur_frame(11'($urandom_range(3, 12)), 11'($urandom_range(3, 8)), 1'b1, 1'b0, clean);

    in_valid_i <= 1'b0;
    while (smoothed_q.size() != 0) @(posedge clk_i);
    repeat (END_CYCLES) @(posedge clk_i);
    if (err_cnt == 0 && smoothed_q.size() == 0) $display("gaussian_blur_3x3_rgb_tb OK");
    else $display("gaussian_blur_3x3_rgb_tb NOT OK");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("gaussian_blur_3x3_rgb_tb NOT OK");
    $finish;
  end

endmodule
